// ----- rtl/wrbh_pkg.sv -----
// ----------------------------------------------------------------------------
// wrbh_pkg
// Shared types, constants and mix function for the word ring byte hash.
// ----------------------------------------------------------------------------
package wrbh_pkg;

	localparam int RING_WORDS = 8;
	localparam int IDX_W      = $clog2(RING_WORDS);

	// ring start values
	localparam logic [31:0] RING_INIT [RING_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0]      digest_word;
		logic [IDX_W-1:0] word_index;
		logic             last_word;
	} dig_t;

	// controller to datapath commands
	typedef struct packed {
		logic             capture;
		logic             mix_step;
		logic             emit_step;
		logic [IDX_W-1:0] idx;
	} wrbh_cmd_t;

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
		rotr32 = (x >> n) | (x << (32 - n));
	endfunction

	// a + s0(a) + b + s1(b) + c
	function automatic logic [31:0] mix_word(input logic [31:0] a,
	                                         input logic [31:0] b,
	                                         input logic [31:0] c);
		logic [31:0] s0;
		logic [31:0] s1;
		s1 = rotr32(b, 25) ^ rotr32(b, 11) ^ b;
		s0 = rotr32(a, 22) ^ rotr32(a, 13) ^ rotr32(a, 2);
		mix_word = a + s0 + b + s1 + c;
	endfunction

endpackage

// ----- rtl/wrbh_ctrl.sv -----
// ----------------------------------------------------------------------------
// wrbh_ctrl
// Sequencer: accepts a request, steps the mix eight times for a byte, then the output at a message end.
// ----------------------------------------------------------------------------
module wrbh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	input  logic                has_byte,
	input  logic                end_of_message,
	output logic                msg_stall,
	output logic                dig_valid,
	input  logic                dig_stall,
	output wrbh_pkg::wrbh_cmd_t cmd
);
	import wrbh_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_EMIT
	} state_t;

	localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(RING_WORDS - 1);

	state_t           state_q;
	logic [IDX_W-1:0] step_q;
	logic             end_q;
	logic             dig_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			end_q       <= 1'b0;
			dig_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_valid) begin
						step_q <= '0;
						end_q  <= end_of_message;
						if (has_byte) begin
							state_q <= ST_MIX;
						end else if (end_of_message) begin
							state_q     <= ST_EMIT;
							dig_valid_q <= 1'b1;
						end
					end
				end
				ST_MIX: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						if (end_q) begin
							state_q     <= ST_EMIT;
							dig_valid_q <= 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (!dig_stall) begin
						step_q <= step_q + 1'b1;
						if (step_q == STEP_LAST) begin
							state_q     <= ST_IDLE;
							dig_valid_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					dig_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign msg_stall     = (state_q != ST_IDLE);
	assign dig_valid     = dig_valid_q;
	assign cmd.capture   = (state_q == ST_IDLE) && msg_valid && has_byte;
	assign cmd.mix_step  = (state_q == ST_MIX);
	assign cmd.emit_step = (state_q == ST_EMIT) && !dig_stall;
	assign cmd.idx       = step_q;

endmodule

// ----- rtl/wrbh_dp.sv -----
// ----------------------------------------------------------------------------
// wrbh_dp
// Rotating ring of eight words with one shared mix unit at its head.
// ----------------------------------------------------------------------------
module wrbh_dp (
	input  logic                clk,
	input  logic [7:0]          data_byte,
	input  wrbh_pkg::wrbh_cmd_t cmd,
	output wrbh_pkg::dig_t      dig,
	input  logic                arst_n
);
	import wrbh_pkg::*;

	logic [7:0]  byte_q;
	logic [31:0] ring_q [RING_WORDS];
	logic [31:0] mix_out;
	logic [31:0] byte_ext;

	assign byte_ext = {{24{byte_q[7]}}, byte_q};
	// head word mixes with its ring neighbor; new word enters at the tail
	assign mix_out  = mix_word(ring_q[0], ring_q[1], byte_ext);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_WORDS; i++) begin
				ring_q[i] <= RING_INIT[i];
			end
		end else if (cmd.mix_step || cmd.emit_step) begin
			for (int i = 0; i < RING_WORDS - 1; i++) begin
				ring_q[i] <= ring_q[i + 1];
			end
			// emitting refills the tail with start values in order
			ring_q[RING_WORDS - 1] <= cmd.mix_step ? mix_out : RING_INIT[cmd.idx];
		end
	end

	assign dig.digest_word = ring_q[0];
	assign dig.word_index  = cmd.idx;
	assign dig.last_word   = (cmd.idx == IDX_W'(RING_WORDS - 1));

endmodule

// ----- rtl/word_ring_byte_hash_unit.sv -----
// ----------------------------------------------------------------------------
// word_ring_byte_hash_unit
// Byte-serial hash over a ring of eight 32-bit words, digest out word by word.
// ----------------------------------------------------------------------------
// Each request carries one message byte (sign-extended before mixing), a flag
// that says whether the byte is present, and an end-of-message flag. A request
// with a byte is accepted, then the single mix unit updates one ring word per
// cycle, word 0 first, because each update feeds the next; the next request is
// held off until all eight words are done. A request marked as the end then
// sends the eight digest words, word 0 first, one per cycle when the output is
// not stalled, and the ring goes back to the start values as the words leave.
// A request with neither flag is taken and changes nothing.
// ----------------------------------------------------------------------------
module word_ring_byte_hash_unit (
	input  logic            clk,
	input  logic            arst_n,
	// request channel
	input  logic            msg_valid,
	output logic            msg_stall,
	input  wrbh_pkg::msg_t  msg,
	// digest channel
	output logic            dig_valid,
	input  logic            dig_stall,
	output wrbh_pkg::dig_t  dig
);
	import wrbh_pkg::*;

	wrbh_cmd_t cmd;

	// sequencer: owns the step count and both handshakes
	wrbh_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.has_byte       (msg.has_byte),
		.end_of_message (msg.end_of_message),
		.msg_stall      (msg_stall),
		.dig_valid      (dig_valid),
		.dig_stall      (dig_stall),
		.cmd            (cmd)
	);

	// ring registers and mix unit; the ring head is the digest word on output
	wrbh_dp u_dp (
		.clk       (clk),
		.data_byte (msg.data_byte),
		.cmd       (cmd),
		.dig       (dig),
		.arst_n    (arst_n)
	);

endmodule

// ----- verif/wrbh_digest_checker.sv -----
// ----------------------------------------------------------------------------
// wrbh_digest_checker
// Watches both channels of the word ring byte hash and checks every digest.
// ----------------------------------------------------------------------------
// Keeps its own copy of the eight ring words and folds in each accepted
// request. A request that ends a message queues the eight digest words it
// should produce. Each accepted digest word is then compared with the oldest
// queued word, field by field.
// ----------------------------------------------------------------------------
module wrbh_digest_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            msg_valid,
	input  logic            msg_stall,
	input  wrbh_pkg::msg_t  msg,
	input  logic            dig_valid,
	input  logic            dig_stall,
	input  wrbh_pkg::dig_t  dig,
	output int              fail_count,
	output int              pending,
	output int              words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import wrbh_pkg::*;

	logic [31:0] ring [RING_WORDS];
	dig_t        digest_due [$];
	int          fails;
	int          checked;

	// a + sigma(a) + b + sigma(b) + byte, rotations written as fixed slices
	function automatic logic [31:0] ring_mix(input logic [31:0] a,
	                                         input logic [31:0] b,
	                                         input logic [31:0] c);
		logic [31:0] sig_a;
		logic [31:0] sig_b;
		sig_b = {b[24:0], b[31:25]} ^ {b[10:0], b[31:11]} ^ b;
		sig_a = {a[21:0], a[31:22]} ^ {a[12:0], a[31:13]} ^ {a[1:0], a[31:2]};
		return a + sig_a + b + sig_b + c;
	endfunction

	task automatic absorb_request(input msg_t m);
		logic [31:0] ext;
		dig_t        w;
		int          k;
		ext = {{24{m.data_byte[7]}}, m.data_byte};
		if (m.has_byte) begin
			// word 7 sees word 0 already updated in this pass
			for (k = 0; k < RING_WORDS; k++)
				ring[k] = ring_mix(ring[k], ring[(k + 1) % RING_WORDS], ext);
		end
		if (m.end_of_message) begin
			for (k = 0; k < RING_WORDS; k++) begin
				w.digest_word = ring[k];
				w.word_index  = IDX_W'(k);
				w.last_word   = (k == RING_WORDS - 1);
				digest_due    = {digest_due, w};
			end
			ring = RING_INIT;
		end
	endtask

	task automatic check_word(input dig_t got);
		dig_t want;
		bit   bad;
		bad = 1'b0;
		if (digest_due.size() == 0) begin
			fails++;
			$display("%0t: unexpected digest word %h index %0d last %b",
			         $time, got.digest_word, got.word_index, got.last_word);
		end else begin
			want = digest_due.pop_front();
			checked++;
			if (got.digest_word !== want.digest_word) begin
				bad = 1'b1;
				$display("%0t: digest_word expected %h got %h",
				         $time, want.digest_word, got.digest_word);
			end
			if (got.word_index !== want.word_index) begin
				bad = 1'b1;
				$display("%0t: word_index expected %0d got %0d",
				         $time, want.word_index, got.word_index);
			end
			if (got.last_word !== want.last_word) begin
				bad = 1'b1;
				$display("%0t: last_word expected %b got %b",
				         $time, want.last_word, got.last_word);
			end
			if (bad)
				fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring = RING_INIT;
			digest_due.delete();
			fails = 0;
			checked = 0;
		end else begin
			if (dig_valid && !dig_stall)
				check_word(dig);
			if (msg_valid && !msg_stall)
				absorb_request(msg);
		end
		fail_count    <= fails;
		pending       <= digest_due.size();
		words_checked <= checked;
	end

endmodule

// ----- verif/tb_word_ring_byte_hash_unit.sv -----
// ----------------------------------------------------------------------------
// tb_word_ring_byte_hash_unit
// Self-checking testbench for the word ring byte hash unit.
// ----------------------------------------------------------------------------
// Sends a short directed set of requests (empty message, byte extremes, sign
// extension, ignored requests in and out of a message), then random messages
// of mostly short length with ignored requests sprinkled in. Both channels
// idle at random, with calm stretches and long receiver hold-offs that back
// the unit up into its request channel. The checker beside the unit predicts
// and compares every digest word.
// ----------------------------------------------------------------------------
module tb_word_ring_byte_hash_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import wrbh_pkg::*;

	localparam int REQUEST_TARGET  = 470;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int TAIL_CYCLES     = 24;
	localparam int CYCLE_LIMIT     = 2000000;

	logic clk = 1'b0;
	logic arst_n;

	// request channel
	logic msg_valid;
	logic msg_stall;
	msg_t msg;

	// digest channel
	logic dig_valid;
	logic dig_stall;
	dig_t dig;

	// checker status
	int fail_count;
	int pending;
	int words_checked;

	// stimulus bookkeeping
	int  requests_taken = 0;
	int  byte_requests  = 0;
	int  message_ends   = 0;
	int  ignored_taken  = 0;
	int  hold_offs      = 0;
	int  cycle_count    = 0;
	bit  calm           = 1'b0;
	bit  hold_due       = 1'b0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	word_ring_byte_hash_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	wrbh_digest_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_valid     (msg_valid),
		.msg_stall     (msg_stall),
		.msg           (msg),
		.dig_valid     (dig_valid),
		.dig_stall     (dig_stall),
		.dig           (dig),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked)
	);

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("word_ring_byte_hash_unit verification failed");
			$finish;
		end
	end

	// idle length between requests: mostly none, some short, a few long
	function automatic int sender_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(12, 4);
		else
			return $urandom_range(50, 20);
	endfunction

	// offer one request, hold it until accepted, then maybe idle
	task automatic offer_request(input logic [7:0] b, input logic h, input logic e);
		int gap;
		msg       <= '{data_byte: b, has_byte: h, end_of_message: e};
		msg_valid <= 1'b1;
		// accepted at the first edge where the unit does not stall
		do @(posedge clk); while (msg_stall);
		if (h || e)
			requests_taken++;
		else
			ignored_taken++;
		if (h)
			byte_requests++;
		if (e)
			message_ends++;
		gap = sender_gap();
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one random message; the end rides on the last byte or comes on its own
	task automatic send_message(input int n_bytes, input bit end_on_byte);
		int i;
		for (i = 0; i < n_bytes; i++) begin
			// ignored request mixed into the message now and then
			if ($urandom_range(99) < 8)
				offer_request(8'($urandom_range(255)), 1'b0, 1'b0);
			offer_request(8'($urandom_range(255)), 1'b1,
			              end_on_byte && (i == n_bytes - 1));
		end
		if (!(end_on_byte && n_bytes > 0))
			offer_request(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// digest receiver: random stalls, calm stretches, and long hold-offs
	initial begin : digest_sink
		int r;
		int run;
		dig_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_due) begin
				// long hold-off so digests back up and the unit stalls requests
				hold_due = 1'b0;
				hold_offs++;
				dig_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (calm) begin
				dig_stall <= 1'b0;
				@(posedge clk);
			end else begin
				r = $urandom_range(99);
				if (r < 55) begin
					dig_stall <= 1'b0;
					run = $urandom_range(8, 1);
				end else if (r < 85) begin
					dig_stall <= 1'b1;
					run = $urandom_range(3, 1);
				end else if (r < 97) begin
					dig_stall <= 1'b1;
					run = $urandom_range(12, 4);
				end else begin
					dig_stall <= 1'b1;
					run = $urandom_range(60, 20);
				end
				repeat (run) @(posedge clk);
			end
		end
	end

	// request stimulus and verdict
	initial begin : request_source
		int  message_no;
		int  n_bytes;
		int  r;
		bit  second_hold;
		message_no  = 0;
		second_hold = 1'b0;
		arst_n    <= 1'b0;
		msg_valid <= 1'b0;
		msg       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message: end with no byte straight after reset
		offer_request(8'h00, 1'b0, 1'b1);
		// single zero byte, then all-ones byte that sign-extends
		offer_request(8'h00, 1'b1, 1'b1);
		offer_request(8'hff, 1'b1, 1'b1);
		// most negative then most positive byte
		offer_request(8'h80, 1'b1, 1'b0);
		offer_request(8'h7f, 1'b1, 1'b1);
		// ignored request while no message is open
		offer_request(8'h5a, 1'b0, 1'b0);
		// ignored request inside a message, end with no byte
		offer_request(8'h55, 1'b1, 1'b0);
		offer_request(8'h33, 1'b0, 1'b0);
		offer_request(8'haa, 1'b1, 1'b0);
		offer_request(8'hc3, 1'b0, 1'b1);
		// empty again right after a digest, ring must be back at its start
		offer_request(8'h00, 1'b0, 1'b1);
		// byte carries the end: mixed first, then the digest
		offer_request(8'h01, 1'b1, 1'b0);
		offer_request(8'hfe, 1'b1, 1'b0);
		offer_request(8'h80, 1'b1, 1'b1);

		// random messages, first hold-off right as they start
		hold_due = 1'b1;
		while ((requests_taken + ignored_taken) < REQUEST_TARGET) begin
			// a calm stretch every so often: no idling on either side
			calm = (message_no % 16) < 2;
			r = $urandom_range(99);
			if (r < 70)
				n_bytes = $urandom_range(4, 0);
			else if (r < 95)
				n_bytes = $urandom_range(12, 5);
			else
				n_bytes = $urandom_range(30, 13);
			send_message(n_bytes, 1'($urandom_range(1)));
			message_no++;
			if (!second_hold &&
			    (requests_taken + ignored_taken) >= REQUEST_TARGET / 2) begin
				second_hold = 1'b1;
				hold_due    = 1'b1;
			end
		end
		calm = 1'b0;
		msg_valid <= 1'b0;

		// let the checker see the last request, then drain the digests
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d bytes, %0d message ends) and %0d ignored",
		         requests_taken, byte_requests, message_ends, ignored_taken);
		$display("checked %0d digest words across %0d receiver hold-offs",
		         words_checked, hold_offs);
		if (fail_count == 0 && pending == 0) begin
			$display("word_ring_byte_hash_unit verification clean");
		end else begin
			$display("word_ring_byte_hash_unit verification failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/wrbh_pkg.sv
rtl/wrbh_ctrl.sv
rtl/wrbh_dp.sv
rtl/word_ring_byte_hash_unit.sv
verif/wrbh_digest_checker.sv
verif/tb_word_ring_byte_hash_unit.sv
